// File: hw/rtl/cda_pkg.sv
// shared types, constants and calendar helper functions for the date unit
// no dependencies
`default_nettype none
package cda_pkg;

    localparam int unsigned EpochYear = 1600;
    localparam int unsigned MinYear   = 1900;
    localparam int unsigned MaxYear   = 2030;
    localparam int unsigned QueueDepth = 2;

    // serial day number, days since 1600-01-01
    localparam int unsigned SerialW = 18;
    // days from epoch to 1900-01-01
    localparam logic [SerialW-1:0] MinSerial = 18'd109573;

    typedef enum logic [1:0] {
        ACT_NEXT = 2'd0,
        ACT_PREV = 2'd1,
        ACT_ADD  = 2'd2,
        ACT_SUB  = 2'd3
    } t_action;

    // classified item handed from front to back
    typedef struct packed {
        logic [SerialW-1:0] serial_first;
        logic [SerialW-1:0] serial_result;
        logic               first_is_earlier;
        logic [15:0]        day_difference;
        logic               first_was_valid;
    } t_item;

    // x / 100 by reciprocal multiplication, exact for 11-bit x
    function automatic logic [4:0] div100(input logic [10:0] x);
        logic [23:0] p;
        begin
            p = 24'(x) * 24'd5243;
            div100 = p[23:19];
        end
    endfunction

    // leap test with y / 100 by reciprocal multiplication, exact for 12-bit y
    function automatic logic is_leap(input logic [11:0] y);
        logic [24:0] p;
        logic [5:0]  q100;
        logic [11:0] r100;
        begin
            p    = 25'(y) * 25'd5243;
            q100 = p[24:19];
            r100 = y - 12'(q100) * 12'd100;
            is_leap = (y[1:0] == 2'b00) && ((r100 != 12'd0) || (q100[1:0] == 2'b00));
        end
    endfunction

    function automatic logic [4:0] days_in_month(input logic [11:0] y, input logic [3:0] m);
        begin
            case (m)
                4'd2:    days_in_month = is_leap(y) ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: days_in_month = 5'd30;
                default: days_in_month = 5'd31;
            endcase
        end
    endfunction

    // days before month m in year y
    function automatic logic [8:0] days_before(input logic [11:0] y, input logic [3:0] m);
        logic [8:0] t;
        begin
            case (m)
                4'd1:    t = 9'd0;
                4'd2:    t = 9'd31;
                4'd3:    t = 9'd59;
                4'd4:    t = 9'd90;
                4'd5:    t = 9'd120;
                4'd6:    t = 9'd151;
                4'd7:    t = 9'd181;
                4'd8:    t = 9'd212;
                4'd9:    t = 9'd243;
                4'd10:   t = 9'd273;
                4'd11:   t = 9'd304;
                default: t = 9'd334;
            endcase
            days_before = t + ((m > 4'd2 && is_leap(y)) ? 9'd1 : 9'd0);
        end
    endfunction

    // days from epoch to start of year, k = y - epoch
    function automatic logic [SerialW-1:0] year_start(input logic [9:0] k);
        logic [SerialW-1:0] a;
        begin
            a = SerialW'(k) * SerialW'(365);
            year_start = a + SerialW'((11'(k) + 11'd3) >> 2)
                         - SerialW'(div100(11'(k) + 11'd99))
                         + SerialW'(div100(11'(k) + 11'd399) >> 2);
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/calendar_date_arithmetic.sv
// calendar date unit top level: front end, queue and back end
// depends on cda_pkg, cda_front, cda_queue, cda_back
// the back end converts one item at a time, stepping through years then months
// front end and queue accept following items while the back end works
// reset: synchronous active low, empties the queue and idles both ends
`default_nettype none
module calendar_date_arithmetic #(
    parameter int unsigned QueueDepth = cda_pkg::QueueDepth
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output logic              o_ready,
    input  wire  logic [1:0]  i_action,
    input  wire  logic [11:0] i_year,
    input  wire  logic [3:0]  i_month,
    input  wire  logic [4:0]  i_day,
    input  wire  logic [15:0] i_amount,
    input  wire  logic [11:0] i_other_year,
    input  wire  logic [3:0]  i_other_month,
    input  wire  logic [4:0]  i_other_day,
    output logic              o_valid,
    input  wire  logic        i_ready,
    output logic [11:0]       o_result_year,
    output logic [3:0]        o_result_month,
    output logic [4:0]        o_result_day,
    output logic              o_first_is_earlier,
    output logic [15:0]       o_day_difference,
    output logic              o_first_was_valid
);
    cda_pkg::t_item f_item, q_item;
    logic f_valid, f_ready, q_valid, q_ready;

    cda_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_year, .i_month, .i_day, .i_amount,
        .i_other_year, .i_other_month, .i_other_day,
        .o_item_valid(f_valid), .i_item_ready(f_ready), .o_item(f_item)
    );

    cda_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_item)
    );

    cda_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid, .i_ready,
        .o_result_year, .o_result_month, .o_result_day,
        .o_first_is_earlier, .o_day_difference, .o_first_was_valid
    );
endmodule
`default_nettype wire

// File: hw/rtl/cda_front.sv
// front end: validates both dates, converts to serial days, applies the action
// depends on cda_pkg
`default_nettype none
module cda_front (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output logic              o_ready,
    input  wire  logic [1:0]  i_action,
    input  wire  logic [11:0] i_year,
    input  wire  logic [3:0]  i_month,
    input  wire  logic [4:0]  i_day,
    input  wire  logic [15:0] i_amount,
    input  wire  logic [11:0] i_other_year,
    input  wire  logic [3:0]  i_other_month,
    input  wire  logic [4:0]  i_other_day,
    output logic              o_item_valid,
    input  wire  logic        i_item_ready,
    output cda_pkg::t_item    o_item
);
    localparam int unsigned W = cda_pkg::SerialW;

    logic          ok1, ok2;
    logic [W-1:0]  s1, s2, sr;
    logic [W-1:0]  r_s1, r_s2, n_s1, n_s2;
    logic [15:0]   r_amt;
    logic [1:0]    r_act;
    logic          r_ok1, r_busy;

    function automatic logic date_ok(input logic [11:0] y, input logic [3:0] m,
                                     input logic [4:0] d);
        begin
            date_ok = (y >= 12'(cda_pkg::MinYear)) && (y <= 12'(cda_pkg::MaxYear))
                      && (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1)
                      && (d <= cda_pkg::days_in_month(y, m));
        end
    endfunction

    function automatic logic [W-1:0] to_serial(input logic [11:0] y, input logic [3:0] m,
                                               input logic [4:0] d);
        begin
            to_serial = cda_pkg::year_start(10'(y - 12'(cda_pkg::EpochYear)))
                        + W'(cda_pkg::days_before(y, m)) + W'(d) - W'(1);
        end
    endfunction

    // stage 1: validation and serial conversion
    always_comb begin
        ok1  = date_ok(i_year, i_month, i_day);
        ok2  = date_ok(i_other_year, i_other_month, i_other_day);
        n_s1 = ok1 ? to_serial(i_year, i_month, i_day) : cda_pkg::MinSerial;
        n_s2 = ok2 ? to_serial(i_other_year, i_other_month, i_other_day)
                   : cda_pkg::MinSerial;
    end

    assign o_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_busy <= 1'b1;
        end else if (i_item_ready) begin
            r_busy <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_amt <= i_amount;
            r_act <= i_action;
            r_ok1 <= ok1;
        end
    end

    // stage 2: action and compare
    always_comb begin
        s1 = r_s1;
        s2 = r_s2;
        case (cda_pkg::t_action'(r_act))
            cda_pkg::ACT_NEXT: sr = s1 + W'(1);
            cda_pkg::ACT_PREV: sr = s1 - W'(1);
            cda_pkg::ACT_ADD:  sr = s1 + W'(r_amt);
            default:           sr = s1 - W'(r_amt);
        endcase
    end

    assign o_item_valid            = r_busy;
    assign o_item.serial_first     = s1;
    assign o_item.serial_result    = sr;
    assign o_item.first_is_earlier = s1 < s2;
    assign o_item.day_difference   = (s1 > s2) ? 16'(s1 - s2) : 16'(s2 - s1);
    assign o_item.first_was_valid  = r_ok1;
endmodule
`default_nettype wire

// File: hw/rtl/cda_queue.sv
// small fifo between front and back
// depends on cda_pkg
`default_nettype none
module cda_queue #(
    parameter int unsigned Depth = cda_pkg::QueueDepth
) (
    input  wire  logic     i_clk,
    input  wire  logic     i_rst_n,
    input  wire  logic     i_valid,
    output logic           o_ready,
    input  cda_pkg::t_item i_data,
    output logic           o_valid,
    input  wire  logic     i_ready,
    output cda_pkg::t_item o_data
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    cda_pkg::t_item r_mem [Depth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           push, pop;

    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + AW'(1);
            if (pop)  r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("queue count overflow");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + (AW+1)'(1)) else $error("bad push count");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_cnt == $past(r_cnt) - (AW+1)'(1)) else $error("bad pop count");
endmodule
`default_nettype wire

// File: hw/rtl/cda_back.sv
// back end: converts the result serial day back to a calendar date
// iterates over years then months; depends on cda_pkg
`default_nettype none
module cda_back (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output logic              o_ready,
    input  cda_pkg::t_item    i_item,
    output logic              o_valid,
    input  wire  logic        i_ready,
    output logic [11:0]       o_result_year,
    output logic [3:0]        o_result_month,
    output logic [4:0]        o_result_day,
    output logic              o_first_is_earlier,
    output logic [15:0]       o_day_difference,
    output logic              o_first_was_valid
);
    localparam int unsigned W = cda_pkg::SerialW;

    typedef enum logic [1:0] {ST_IDLE, ST_YEAR, ST_MONTH, ST_DONE} t_state;

    t_state       r_state;
    logic [9:0]   r_k;
    logic [W-1:0] r_rem;
    logic [3:0]   r_m;
    logic [11:0]  yy;
    logic [W-1:0] ys_next;
    logic [4:0]   mlen;

    assign yy      = 12'(cda_pkg::EpochYear) + 12'(r_k);
    assign ys_next = cda_pkg::year_start(r_k + 10'd1);
    assign mlen    = cda_pkg::days_in_month(yy, r_m);
    assign o_ready = r_state == ST_IDLE;
    assign o_valid = r_state == ST_DONE;

    // year search starts at the epoch year, month search at january
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_k   <= 10'd0;
                        r_rem <= i_item.serial_result;
                        r_m   <= 4'd1;
                        o_first_is_earlier <= i_item.first_is_earlier;
                        o_day_difference   <= i_item.day_difference;
                        o_first_was_valid  <= i_item.first_was_valid;
                        r_state <= ST_YEAR;
                    end
                end
                ST_YEAR: begin
                    // step a year at a time; r_rem stays the absolute serial
                    if (ys_next <= r_rem) begin
                        r_k <= r_k + 10'd1;
                    end else begin
                        r_rem   <= r_rem - cda_pkg::year_start(r_k);
                        r_state <= ST_MONTH;
                    end
                end
                ST_MONTH: begin
                    if (r_m < 4'd12 && r_rem >= W'(mlen)) begin
                        r_rem <= r_rem - W'(mlen);
                        r_m   <= r_m + 4'd1;
                    end else begin
                        o_result_year  <= yy;
                        o_result_month <= r_m;
                        o_result_day   <= 5'(r_rem) + 5'd1;
                        r_state        <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_month >= 4'd1 && o_result_month <= 4'd12))
        else $error("month out of range");
    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_day != 5'd0) else $error("zero day");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_year))
        else $error("result dropped");
endmodule
`default_nettype wire
